// ===== src/jbce_pkg.sv =====
// Package: shared types and constants for the JTAG byte command engine.
`timescale 1ns / 1ps
`default_nettype none
package jbce_pkg;

    localparam int BYTE_W      = 8;
    localparam int PIN_W       = 6;
    localparam int HDR_CNT_W   = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int BIT_IDX_W   = 3;

    // Pin layout in command order: 0 TCK, 1 TMS, 2/3/5 aux, 4 TDI.
    localparam int PIN_TCK  = 0;
    localparam int PIN_TMS  = 1;
    localparam int PIN_AUX0 = 2;
    localparam int PIN_AUX1 = 3;
    localparam int PIN_TDI  = 4;
    localparam int PIN_AUX2 = 5;

    localparam int CMD_SHIFT_BIT = 7;
    localparam int CMD_READ_BIT  = 6;

    // TMS and aux pins, held during a shift.
    localparam logic [PIN_W-1:0] HELD_MASK = 6'b10_1110;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;

    typedef logic [BYTE_W-1:0] byte_t;

    // One queued work item for the back end.
    typedef struct packed {
        logic             is_shift; // payload byte: eight pulses
        logic [PIN_W-1:0] pins;     // full pins (bit-bang) or held pins (shift)
        byte_t            data;     // payload bits to shift
        byte_t            rdata;    // byte returned on the final result, zero if none
        logic             rvalid;   // final result carries a read byte
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// ===== src/jbce_front.sv =====
// Front end: accepts command bytes, tracks mode and pins, queues work items.
`timescale 1ns / 1ps
`default_nettype none
module jbce_front #(
    parameter int MAX_SHIFT_BYTES = 63
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,
    input  wire jbce_pkg::q_status_t q_status,
    output logic                   push,
    output jbce_pkg::desc_t        push_desc
);
    import jbce_pkg::*;

    localparam int CNT_W = $clog2(MAX_SHIFT_BYTES + 1);
    localparam logic [HDR_CNT_W-1:0] MAX_CNT = HDR_CNT_W'(MAX_SHIFT_BYTES);

    logic [CNT_W-1:0]  bytes_left_reg, bytes_left_next;
    logic              rd_en_reg, rd_en_next;
    logic [PIN_W-1:0]  pins_reg, pins_next;

    byte_t                cmd;
    byte_t                tdo;
    logic                 accept;
    logic                 in_shift;
    logic [HDR_CNT_W-1:0] cnt_sat;
    logic [PIN_W-1:0]     held;

    assign cmd      = s_tdata[7:0];
    assign tdo      = s_tdata[15:8];
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign in_shift = (bytes_left_reg != '0);
    assign held     = pins_reg & HELD_MASK;
    assign cnt_sat  = (cmd[HDR_CNT_W-1:0] > MAX_CNT) ? MAX_CNT : cmd[HDR_CNT_W-1:0];

    always_comb begin
        bytes_left_next = bytes_left_reg;
        rd_en_next      = rd_en_reg;
        pins_next       = pins_reg;
        push            = 1'b0;
        push_desc       = '0;
        if (accept) begin
            priority if (in_shift) begin
                push               = 1'b1;
                push_desc.is_shift = 1'b1;
                push_desc.pins     = held;
                push_desc.data     = cmd;
                push_desc.rvalid   = rd_en_reg;
                push_desc.rdata    = rd_en_reg ? tdo : '0;
                pins_next          = held;
                pins_next[PIN_TDI] = cmd[BYTE_W-1];
                bytes_left_next    = bytes_left_reg - CNT_W'(1);
                if (bytes_left_next == '0) begin
                    rd_en_next = 1'b0;
                end
            end else if (cmd[CMD_SHIFT_BIT]) begin
                bytes_left_next = CNT_W'(cnt_sat);
                rd_en_next      = (cnt_sat != '0) && cmd[CMD_READ_BIT];
            end else begin
                push               = 1'b1;
                push_desc.is_shift = 1'b0;
                push_desc.pins     = cmd[PIN_W-1:0];
                push_desc.data     = '0;
                push_desc.rvalid   = cmd[CMD_READ_BIT];
                push_desc.rdata    = cmd[CMD_READ_BIT] ? {{(BYTE_W-1){1'b0}}, tdo[0]} : '0;
                pins_next          = cmd[PIN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            rd_en_reg      <= 1'b0;
            pins_reg       <= '0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            rd_en_reg      <= rd_en_next;
            pins_reg       <= pins_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/jbce_queue.sv =====
// Short work item queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module jbce_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire jbce_pkg::desc_t push_desc,
    input  wire logic            pop,
    output jbce_pkg::desc_t      head,
    output jbce_pkg::q_status_t  status
);
    import jbce_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/jbce_back.sv =====
// Back end: expands queued work items into results, one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module jbce_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire jbce_pkg::desc_t     head,
    input  wire jbce_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [15:0]              m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);
    import jbce_pkg::*;

    desc_t                desc_reg;
    logic                 active_reg, active_next;
    logic [BIT_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_data_reg;
    logic [1:0]           out_user_reg;
    logic                 out_last_reg;

    logic        advance;
    logic        final_bit;
    logic        load;
    logic [15:0] res_data;
    logic [1:0]  res_user;

    assign advance   = active_reg && (!out_valid_reg || m_tready);
    assign final_bit = !desc_reg.is_shift || (idx_reg == LAST_BIT_IDX);
    assign load      = !active_reg || (advance && final_bit);
    assign pop       = load && !q_status.empty;

    always_comb begin
        res_data        = '0;
        res_data[0]     = desc_reg.is_shift ? 1'b0 : desc_reg.pins[PIN_TCK];
        res_data[1]     = desc_reg.pins[PIN_TMS];
        res_data[2]     = desc_reg.is_shift ? desc_reg.data[idx_reg] : desc_reg.pins[PIN_TDI];
        res_data[5:3]   = {desc_reg.pins[PIN_AUX2], desc_reg.pins[PIN_AUX1],
                           desc_reg.pins[PIN_AUX0]};
        res_data[13:6]  = final_bit ? desc_reg.rdata : '0;
        res_user[0]     = desc_reg.is_shift;
        res_user[1]     = final_bit && desc_reg.rvalid;
    end

    always_comb begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (load) begin
            active_next = !q_status.empty;
        end
        if (pop) begin
            idx_next = '0;
        end else if (advance) begin
            idx_next = idx_reg + BIT_IDX_W'(1);
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            desc_reg <= head;
        end
        if (advance) begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
            out_last_reg <= final_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== src/jtag_byte_command_engine.sv =====
// Top level: JTAG byte command engine, front end, work queue and back end.
// A bit-bang byte's result is registered in the queue, then in the back end load and output registers.
// Throughput: one input byte per cycle while the queue has room; the back end emits one result
// per cycle while the output is not stalled, so a payload byte yields eight pulse results.
// Shift headers yield no result and queue no work item.
// Reset (aresetn low, synchronous): bit-bang mode, all pins low, queue and output emptied.
`timescale 1ns / 1ps
`default_nettype none
module jtag_byte_command_engine #(
    parameter int MAX_SHIFT_BYTES = 63
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [7:0] cmd_byte, [15:8] tdo_levels
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // [0] tck_level, [1] tms_level, [2] tdi_level,
                                       // [5:3] aux_pins, [13:6] read_data, [15:14] zero
    output logic [1:0]       m_tuser,  // [0] clock_pulse, [1] read_valid
    output logic             m_tlast   // last
);
    import jbce_pkg::*;

    q_status_t q_status;
    logic      push;
    desc_t     push_desc;
    logic      pop;
    desc_t     head;

    jbce_front #(
        .MAX_SHIFT_BYTES(MAX_SHIFT_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    jbce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    jbce_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== src/jbce_checker.sv =====
// Port-level checker for the JTAG byte command engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module jbce_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result transaction changed");

    a_pulse_tck_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[0])
        else $error("TCK high on a shift pulse result");

    a_read_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("read byte on a result that is not last");

    a_no_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[13:6] == 8'h00)
        else $error("read data nonzero without read valid");

endmodule

bind jtag_byte_command_engine jbce_checker u_jbce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
